// ===== hdl/hbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// hbpa_pkg
// Types and constants shared by the hierarchical bitmap page allocator.
// ----------------------------------------------------------------------------
package hbpa_pkg;

	// command codes
	typedef enum logic [3:0] {
		OP_ALLOC4K  = 4'd0,
		OP_ALLOC2M  = 4'd1,
		OP_FREE4K   = 4'd2,
		OP_FREE2M   = 4'd3,
		OP_MARK4K   = 4'd4,
		OP_MARK128K = 4'd5,
		OP_MARK2M   = 4'd6,
		OP_MARK64M  = 4'd7,
		OP_FREE128K = 4'd8,
		OP_FREE64M  = 4'd9
	} op_t;

	// map levels
	localparam logic [1:0] LVL_4K   = 2'd0;
	localparam logic [1:0] LVL_128K = 2'd1;
	localparam logic [1:0] LVL_2M   = 2'd2;
	localparam logic [1:0] LVL_64M  = 2'd3;

	localparam logic [63:0] HIGH_BITS  = 64'haaaa_aaaa_aaaa_aaaa;
	localparam logic [63:0] LOW_BITS   = 64'h5555_5555_5555_5555;
	localparam logic [63:0] UPPER_HALF = 64'hffff_ffff_0000_0000;
	localparam logic [1:0]  ENT_FULL   = 2'b11;
	localparam logic [1:0]  ENT_PART   = 2'b01;
	localparam int unsigned ENTRIES    = 32;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [15:0] page_number;
	} cmd_t;

	typedef struct packed {
		logic        status;
		logic [15:0] granted_page;
	} res_t;

	// control of the shared map update unit
	typedef struct packed {
		logic [1:0] lvl;
		logic       mark;
		logic       partial;
		logic [4:0] entry;
		logic       upper_half;
	} upd_ctrl_t;

endpackage

// ===== hdl/hbpa_map_unit.sv =====
// ----------------------------------------------------------------------------
// hbpa_map_unit
// Updates one two-bit entry of a map word and tests the new word for upward
// propagation of a full or free granule.
// ----------------------------------------------------------------------------
module hbpa_map_unit (
	input  logic [63:0]          word,
	input  hbpa_pkg::upd_ctrl_t  ctrl,
	output logic [63:0]          new_word,
	output logic                 cont
);
	import hbpa_pkg::*;

	logic [5:0]  pos;
	logic [63:0] emask;
	logic [63:0] lmask;
	logic [63:0] hmask;

	// entry masks
	assign pos   = {ctrl.entry, 1'b0};
	assign emask = {62'd0, ENT_FULL} << pos;
	assign lmask = {62'd0, ENT_PART} << pos;
	assign hmask = ctrl.upper_half ? UPPER_HALF : ~UPPER_HALF;

	// new word value
	always_comb begin
		if (ctrl.mark) begin
			new_word = ctrl.partial ? (word | lmask) : (word | emask);
		end else begin
			new_word = ctrl.partial ? ((word & ~emask) | lmask) : (word & ~emask);
		end
	end

	// parent becomes full or free as well
	always_comb begin
		case (ctrl.lvl)
			LVL_4K:   cont = ctrl.mark ? (new_word == '1) : (new_word == '0);
			LVL_128K: cont = ctrl.mark ? ((new_word & HIGH_BITS & hmask) == (HIGH_BITS & hmask))
			                           : ((new_word & hmask) == '0);
			LVL_2M:   cont = ctrl.mark ? ((new_word & HIGH_BITS) == HIGH_BITS)
			                           : (new_word == '0);
			default:  cont = 1'b0;
		endcase
	end

endmodule

// ===== hdl/hbpa_scan.sv =====
// ----------------------------------------------------------------------------
// hbpa_scan
// First-fit search: lowest entry among the first lim whose chosen bit is clear.
// ----------------------------------------------------------------------------
module hbpa_scan (
	input  logic [63:0] word,
	input  logic        hi_sel,
	input  logic [5:0]  lim,
	output logic        found,
	output logic [4:0]  idx
);
	import hbpa_pkg::*;

	// priority encode from the top so the lowest hit wins
	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int k = ENTRIES - 1; k >= 0; k--) begin
			if ((6'(k) < lim) && !word[2 * k + (hi_sel ? 1 : 0)]) begin
				found = 1'b1;
				idx   = 5'(k);
			end
		end
	end

endmodule

// ===== hdl/hier_bitmap_page_allocator.sv =====
// Marks and frees read, then write each memory-held level and write each
// register-held level directly; allocations first scan the maps level by level,
// then mark the granted page. One item at a time; busy stays high meanwhile.
// Reset: the 64M and 2M maps clear at once; a clearing pass then writes the
// 4K and 128K map memories with busy high.
// Results appear for one cycle with done and are not held off by the receiver.
// ----------------------------------------------------------------------------
// hier_bitmap_page_allocator
// Four-level two-bit map page allocator with first-fit 4K and 2M allocation.
// ----------------------------------------------------------------------------
module hier_bitmap_page_allocator #(
	parameter int REGIONS_64M = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  hbpa_pkg::cmd_t   cmd,
	output logic             done,
	output hbpa_pkg::res_t   result
);
	import hbpa_pkg::*;

	localparam int REACH = (REGIONS_64M < 4) ? REGIONS_64M : 4;
	localparam int D4K   = REACH * 512;
	localparam int D128  = REACH * 16;
	localparam int AW4K  = $clog2(D4K);
	localparam int AW128 = $clog2(D128);
	localparam int IW2   = (REACH > 1) ? $clog2(REACH) : 1;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_CLEAR  = 8'b0000_0010,
		ST_SCAN_R = 8'b0000_0100,
		ST_SCAN_K = 8'b0000_1000,
		ST_SCAN_J = 8'b0001_0000,
		ST_SCAN_I = 8'b0010_0000,
		ST_RD     = 8'b0100_0000,
		ST_WR     = 8'b1000_0000
	} state_t;

	state_t           state_q;
	logic [AW4K-1:0]  clr_q;
	logic [3:0]       op_q;
	logic [15:0]      page_q;
	logic [1:0]       lvl_q;
	logic             mark_q;
	logic             part_q;
	logic [1:0]       r_q;
	logic [4:0]       k_q;
	logic             done_q;
	res_t             result_q;

	logic [63:0] mem4k [0:D4K-1];
	logic [63:0] mem128k [0:D128-1];
	logic [63:0] l2_q [0:REACH-1];
	logic [63:0] l64_q;
	logic [63:0] rd4k_q;
	logic [63:0] rd128k_q;

	logic [15:0]  probe;
	logic [63:0]  scan_word;
	logic         scan_hi;
	logic [5:0]   scan_lim;
	logic         scan_found;
	logic [4:0]   scan_idx;
	upd_ctrl_t    uctrl;
	logic [63:0]  cur_word;
	logic [63:0]  new_word;
	logic         cont;
	logic         in_range;
	logic [IW2-1:0] l2_idx;

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	assign in_range = {1'b0, cmd.page_number} < 17'(REACH * 16384);
	assign l2_idx   = page_q[14 +: IW2];

	// probe address for the allocation reads, else the target page
	always_comb begin
		case (state_q)
			ST_SCAN_K: probe = {r_q, scan_idx, 9'd0};
			ST_SCAN_J: probe = {r_q, k_q, scan_idx[3:0], 5'd0};
			default:   probe = page_q;
		endcase
	end

	// scan operand selection
	always_comb begin
		scan_word = l64_q;
		scan_hi   = 1'b1;
		scan_lim  = 6'(REACH);
		case (state_q)
			ST_SCAN_K: begin
				scan_word = l2_q[r_q[IW2-1:0]];
				scan_hi   = (op_q == OP_ALLOC4K);
				scan_lim  = 6'(ENTRIES);
			end
			ST_SCAN_J: begin
				scan_word = {32'hffff_ffff, k_q[0] ? rd128k_q[63:32] : rd128k_q[31:0]};
				scan_hi   = 1'b1;
				scan_lim  = 6'(ENTRIES / 2);
			end
			ST_SCAN_I: begin
				scan_word = rd4k_q;
				scan_hi   = 1'b0;
				scan_lim  = 6'(ENTRIES);
			end
			default: begin
				scan_word = l64_q;
			end
		endcase
	end

	hbpa_scan u_scan (
		.word   (scan_word),
		.hi_sel (scan_hi),
		.lim    (scan_lim),
		.found  (scan_found),
		.idx    (scan_idx)
	);

	// shared entry update
	always_comb begin
		uctrl.lvl        = lvl_q;
		uctrl.mark       = mark_q;
		uctrl.partial    = part_q;
		uctrl.upper_half = page_q[9];
		case (lvl_q)
			LVL_4K:   uctrl.entry = page_q[4:0];
			LVL_128K: uctrl.entry = page_q[9:5];
			LVL_2M:   uctrl.entry = page_q[13:9];
			default:  uctrl.entry = {3'd0, page_q[15:14]};
		endcase
		case (lvl_q)
			LVL_4K:   cur_word = rd4k_q;
			LVL_128K: cur_word = rd128k_q;
			LVL_2M:   cur_word = l2_q[l2_idx];
			default:  cur_word = l64_q;
		endcase
	end

	hbpa_map_unit u_map (
		.word     (cur_word),
		.ctrl     (uctrl),
		.new_word (new_word),
		.cont     (cont)
	);

	// map memories: one write and one registered read a cycle each
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			mem4k[clr_q] <= '0;
		end else if (state_q == ST_WR && lvl_q == LVL_4K) begin
			mem4k[probe[5 +: AW4K]] <= new_word;
		end
		rd4k_q <= mem4k[probe[5 +: AW4K]];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR && {1'b0, clr_q} < (AW4K + 1)'(D128)) begin
			mem128k[clr_q[AW128-1:0]] <= '0;
		end else if (state_q == ST_WR && lvl_q == LVL_128K) begin
			mem128k[probe[10 +: AW128]] <= new_word;
		end
		rd128k_q <= mem128k[probe[10 +: AW128]];
	end

	// register-held upper maps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < REACH; n++) begin
				l2_q[n] <= '0;
			end
			l64_q <= '0;
		end else if (state_q == ST_WR) begin
			if (lvl_q == LVL_2M) begin
				l2_q[l2_idx] <= new_word;
			end
			if (lvl_q == LVL_64M) begin
				l64_q <= new_word;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
			op_q     <= '0;
			page_q   <= '0;
			lvl_q    <= LVL_4K;
			mark_q   <= 1'b0;
			part_q   <= 1'b0;
			r_q      <= '0;
			k_q      <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW4K'(D4K - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						op_q   <= cmd.opcode;
						page_q <= cmd.page_number;
						part_q <= 1'b0;
						case (cmd.opcode)
							OP_ALLOC4K, OP_ALLOC2M: begin
								state_q <= ST_SCAN_R;
							end
							OP_FREE4K, OP_FREE2M, OP_MARK4K, OP_MARK128K,
							OP_MARK2M, OP_MARK64M, OP_FREE128K, OP_FREE64M: begin
								if (in_range) begin
									case (cmd.opcode)
										OP_FREE4K, OP_MARK4K:     lvl_q <= LVL_4K;
										OP_FREE128K, OP_MARK128K: lvl_q <= LVL_128K;
										OP_FREE2M, OP_MARK2M:     lvl_q <= LVL_2M;
										default:                  lvl_q <= LVL_64M;
									endcase
									mark_q <= (cmd.opcode == OP_MARK4K) ||
									          (cmd.opcode == OP_MARK128K) ||
									          (cmd.opcode == OP_MARK2M) ||
									          (cmd.opcode == OP_MARK64M);
									if (cmd.opcode == OP_FREE4K || cmd.opcode == OP_MARK4K ||
									    cmd.opcode == OP_FREE128K ||
									    cmd.opcode == OP_MARK128K) begin
										state_q <= ST_RD;
									end else begin
										state_q <= ST_WR;
									end
								end else begin
									done_q   <= 1'b1;
									result_q <= '0;
								end
							end
							default: begin
								done_q   <= 1'b1;
								result_q <= '0;
							end
						endcase
					end
				end
				ST_SCAN_R: begin
					r_q <= scan_idx[1:0];
					if (scan_found) begin
						state_q <= ST_SCAN_K;
					end else begin
						state_q  <= ST_IDLE;
						done_q   <= 1'b1;
						result_q <= '{status: 1'b1, granted_page: '0};
					end
				end
				ST_SCAN_K: begin
					k_q <= scan_idx;
					if (!scan_found) begin
						state_q  <= ST_IDLE;
						done_q   <= 1'b1;
						result_q <= '{status: 1'b1, granted_page: '0};
					end else if (op_q == OP_ALLOC2M) begin
						page_q  <= {r_q, scan_idx, 9'd0};
						lvl_q   <= LVL_2M;
						mark_q  <= 1'b1;
						state_q <= ST_WR;
					end else begin
						state_q <= ST_SCAN_J;
					end
				end
				ST_SCAN_J: begin
					page_q <= {r_q, k_q, scan_idx[3:0], 5'd0};
					if (scan_found) begin
						state_q <= ST_SCAN_I;
					end else begin
						state_q  <= ST_IDLE;
						done_q   <= 1'b1;
						result_q <= '{status: 1'b1, granted_page: '0};
					end
				end
				ST_SCAN_I: begin
					if (scan_found) begin
						page_q  <= {page_q[15:5], scan_idx};
						lvl_q   <= LVL_4K;
						mark_q  <= 1'b1;
						state_q <= ST_RD;
					end else begin
						state_q  <= ST_IDLE;
						done_q   <= 1'b1;
						result_q <= '{status: 1'b1, granted_page: '0};
					end
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (lvl_q == LVL_64M) begin
						state_q  <= ST_IDLE;
						done_q   <= 1'b1;
						result_q <= '{status: 1'b0,
						              granted_page: ((op_q == OP_ALLOC4K) ||
						                             (op_q == OP_ALLOC2M)) ? page_q : 16'd0};
					end else begin
						if (!cont) begin
							part_q <= 1'b1;
						end
						lvl_q   <= lvl_q + 2'd1;
						state_q <= (lvl_q == LVL_4K) ? ST_RD : ST_WR;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result without work in progress");

	a_fail_zero_page: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status) |-> (result.granted_page == 16'd0))
		else $error("failed allocation returned a page");

	a_start_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item dropped");
`endif

endmodule

// ===== bench/hbpa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbpa_checker
// Watches the command and result channels of the page allocator, keeps its
// own copy of the four maps, predicts each result and compares it.
// ----------------------------------------------------------------------------
module hbpa_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  hbpa_pkg::cmd_t   cmd,
	input  logic             done,
	input  hbpa_pkg::res_t   result,
	output int               errors,
	output int               pending
);
	import hbpa_pkg::*;

	localparam int REGIONS = 4;
	localparam logic [63:0] LOWER_HALF = 64'h0000_0000_ffff_ffff;

	logic [63:0] map4k [REGIONS*512];
	logic [63:0] map128k [REGIONS*16];
	logic [63:0] map2m [REGIONS];
	logic [63:0] map64m;
	res_t expected_q [$];

	// field positions of a page at each level
	function automatic int sh4(int p);   return (p & 31) * 2;        endfunction
	function automatic int sh128(int p); return ((p >> 5) & 31) * 2; endfunction
	function automatic int sh2m(int p);  return ((p >> 9) & 31) * 2; endfunction
	function automatic int sh64(int p);  return ((p >> 14) & 31) * 2; endfunction
	function automatic logic [63:0] half_of(int p);
		return ((p >> 9) & 1) ? UPPER_HALF : LOWER_HALF;
	endfunction

	function automatic logic [63:0] clear_ent(logic [63:0] w, int sh);
		return w & ~(64'd3 << sh);
	endfunction

	function automatic logic [63:0] make_partial(logic [63:0] w, int sh);
		return clear_ent(w, sh) | (64'(ENT_PART) << sh);
	endfunction

	function automatic int first_zero(logic [63:0] w, int n, int b);
		for (int k = 0; k < n; k++)
			if (!w[2*k+b]) return k;
		return n;
	endfunction

	function automatic void set_2m(int p);
		map2m[p>>14] |= 64'(ENT_FULL) << sh2m(p);
		if ((map2m[p>>14] & HIGH_BITS) != HIGH_BITS)
			map64m |= 64'(ENT_PART) << sh64(p);
		else
			map64m |= 64'(ENT_FULL) << sh64(p);
	endfunction

	function automatic void set_128k(int p);
		logic [63:0] m;
		m = half_of(p);
		map128k[p>>10] |= 64'(ENT_FULL) << sh128(p);
		if ((map128k[p>>10] & HIGH_BITS & m) != (HIGH_BITS & m)) begin
			map2m[p>>14] |= 64'(ENT_PART) << sh2m(p);
			map64m |= 64'(ENT_PART) << sh64(p);
		end else begin
			set_2m(p);
		end
	endfunction

	function automatic void set_4k(int p);
		map4k[p>>5] |= 64'(ENT_FULL) << sh4(p);
		if (map4k[p>>5] != '1) begin
			map128k[p>>10] |= 64'(ENT_PART) << sh128(p);
			map2m[p>>14] |= 64'(ENT_PART) << sh2m(p);
			map64m |= 64'(ENT_PART) << sh64(p);
		end else begin
			set_128k(p);
		end
	endfunction

	function automatic void clr_2m(int p);
		map2m[p>>14] = clear_ent(map2m[p>>14], sh2m(p));
		if (map2m[p>>14] != 0) map64m = make_partial(map64m, sh64(p));
		else map64m = clear_ent(map64m, sh64(p));
	endfunction

	function automatic void clr_128k(int p);
		map128k[p>>10] = clear_ent(map128k[p>>10], sh128(p));
		if ((map128k[p>>10] & half_of(p)) != 0) begin
			map2m[p>>14] = make_partial(map2m[p>>14], sh2m(p));
			map64m = make_partial(map64m, sh64(p));
		end else begin
			clr_2m(p);
		end
	endfunction

	function automatic void clr_4k(int p);
		map4k[p>>5] = clear_ent(map4k[p>>5], sh4(p));
		if (map4k[p>>5] != 0) begin
			map128k[p>>10] = make_partial(map128k[p>>10], sh128(p));
			map2m[p>>14] = make_partial(map2m[p>>14], sh2m(p));
			map64m = make_partial(map64m, sh64(p));
		end else begin
			clr_128k(p);
		end
	endfunction

	// first-fit 2M walk
	function automatic void grab_2m(output bit ok, output int page);
		int r, k;
		ok = 0;
		page = 0;
		r = first_zero(map64m, REGIONS, 1);
		if (r >= REGIONS) return;
		if ((~map2m[r] & HIGH_BITS) == 0) return;
		k = first_zero(map2m[r], 32, 0);
		if (k >= 32) return;
		page = (r * 32 + k) * 512;
		ok = 1;
		set_2m(page);
	endfunction

	// first-fit 4K walk
	function automatic void grab_4k(output bit ok, output int page);
		int r, k, j, i, g, c;
		logic [63:0] h;
		ok = 0;
		page = 0;
		r = first_zero(map64m, REGIONS, 1);
		if (r >= REGIONS) return;
		k = first_zero(map2m[r], 32, 1);
		if (k >= 32) return;
		g = r * 32 + k;
		h = (map128k[g>>1] >> ((g & 1) * 32)) | UPPER_HALF;
		j = first_zero(h, 16, 1);
		if (j >= 16) return;
		c = g * 16 + j;
		if ((~map4k[c] & HIGH_BITS) == 0) return;
		i = first_zero(map4k[c], 32, 0);
		if (i >= 32) return;
		page = c * 32 + i;
		ok = 1;
		set_4k(page);
	endfunction

	function automatic res_t predict_grant(cmd_t c);
		res_t r;
		bit ok;
		int pg, p;
		ok = 1;
		pg = 0;
		p = c.page_number;
		case (c.opcode)
			OP_ALLOC4K:  grab_4k(ok, pg);
			OP_ALLOC2M:  grab_2m(ok, pg);
			OP_FREE4K:   clr_4k(p);
			OP_FREE2M:   clr_2m(p);
			OP_MARK4K:   set_4k(p);
			OP_MARK128K: set_128k(p);
			OP_MARK2M:   set_2m(p);
			OP_MARK64M:  map64m |= 64'(ENT_FULL) << sh64(p);
			OP_FREE128K: clr_128k(p);
			OP_FREE64M:  map64m = clear_ent(map64m, sh64(p));
			default: ;
		endcase
		r.status = !ok;
		r.granted_page = ok ? 16'(pg) : 16'd0;
		return r;
	endfunction

	assign pending = expected_q.size();

	// predict on acceptance, compare on done
	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			for (int i = 0; i < REGIONS*512; i++) map4k[i] = '0;
			for (int i = 0; i < REGIONS*16; i++) map128k[i] = '0;
			for (int i = 0; i < REGIONS; i++) map2m[i] = '0;
			map64m = '0;
			expected_q.delete();
			errors = 0;
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %0d/%0d", result.status,
							result.granted_page);
				end else begin
					e = expected_q.pop_front();
					if (e.status !== result.status || e.granted_page !== result.granted_page) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp %0d/%0d got %0d/%0d", e.status,
								e.granted_page, result.status, result.granted_page);
					end
				end
			end
			if (start && !busy)
				expected_q.push_back(predict_grant(cmd));
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the page allocator: directed marks, frees and allocations,
// then random marks, frees and allocations; the checker gives the verdict count.
// ----------------------------------------------------------------------------
module tb_top;
	import hbpa_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	res_t result;
	int errors;
	int pending;

	hier_bitmap_page_allocator u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .result(result)
	);

	hbpa_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// issue one item and wait until busy is low; start stays high when there is no gap
	task automatic issue(op_t op, logic [15:0] pg);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= '{opcode: op, page_number: pg};
		do @(posedge clk); while (busy);
	endtask

	task automatic issue_raw(logic [3:0] op, logic [15:0] pg);
		issue(op_t'(op), pg);
	endtask

	op_t ops [10] = '{OP_ALLOC4K, OP_ALLOC2M, OP_FREE4K, OP_FREE2M, OP_MARK4K,
		OP_MARK128K, OP_MARK2M, OP_MARK64M, OP_FREE128K, OP_FREE64M};

	initial begin
		int base, sel;
		start = 0;
		cmd = '0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, every opcode and unused codes
		issue(OP_ALLOC4K, 16'h0);
		issue(OP_ALLOC2M, 16'hffff);
		issue(OP_MARK4K, 16'hffff);
		issue(OP_MARK128K, 16'h0);
		issue(OP_MARK2M, 16'h8000);
		issue(OP_MARK64M, 16'h4000);
		issue(OP_FREE4K, 16'hffff);
		issue(OP_FREE128K, 16'h0);
		issue(OP_FREE2M, 16'h8000);
		issue(OP_FREE64M, 16'h4000);
		issue_raw(4'd10, 16'h1234);
		issue_raw(4'd15, 16'hffff);
		// whole regions full: allocations fail
		for (int r = 0; r < 4; r++) issue(OP_MARK64M, 16'(r << 14));
		issue(OP_ALLOC4K, 16'h0);
		issue(OP_ALLOC2M, 16'h0);
		for (int r = 0; r < 4; r++) issue(OP_FREE64M, 16'(r << 14));
		// only partial 2M entries in a region: alloc2m fails
		for (int k = 0; k < 32; k++) issue(OP_MARK4K, 16'(k << 9));
		issue(OP_ALLOC2M, 16'h0);
		issue(OP_ALLOC4K, 16'h0);

		// random: allocations, 4K and 128K marks and frees inside a randomly chosen 2M granule, any opcode, unused codes
		for (int n = 0; n < 790; n++) begin
			sel = $urandom_range(0, 99);
			base = $urandom_range(0, 127) << 9;
			if (sel < 30) issue(OP_ALLOC4K, 16'($urandom));
			else if (sel < 38) issue(OP_ALLOC2M, 16'($urandom));
			else if (sel < 55) issue(OP_MARK4K, 16'(base | $urandom_range(0, 511)));
			else if (sel < 70) issue(OP_FREE4K, 16'(base | $urandom_range(0, 511)));
			else if (sel < 78) issue(OP_MARK128K, 16'(base | ($urandom_range(0, 15) << 5)));
			else if (sel < 86) issue(OP_FREE128K, 16'(base | ($urandom_range(0, 15) << 5)));
			else if (sel < 96) issue(ops[$urandom_range(0, 9)], 16'($urandom));
			else issue_raw(4'($urandom_range(10, 15)), 16'($urandom));
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

endmodule
